FILE: design/ascon_xofa_hash_sponge_defines.svh
// Assertion macros for the Ascon-XofA sponge top-level design file.
`ifndef ASCON_XOFA_HASH_SPONGE_DEFINES_SVH
`define ASCON_XOFA_HASH_SPONGE_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define AXH_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("axh: invariant violated");

// Condition that, once seen, must be followed by another in the next cycle.
`define AXH_ASSERT_NEXT(lbl, cause, effect) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
    else $error("axh: sequencing violated");

`endif

FILE: design/axh_pkg.sv
// Types and constants for the Ascon-XofA sponge.
package axh_pkg;

  typedef logic [63:0] axh_lane_t;
  typedef logic [4:0][63:0] axh_state_t;

  typedef struct packed {
    logic [63:0] block_data;
    logic        is_final;
    logic [2:0]  final_bytes;
  } axh_in_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic        digest_last;
  } axh_out_t;

  localparam logic [3:0] ROUNDS_A = 4'd12;
  localparam logic [3:0] ROUNDS_B = 4'd8;
  localparam logic [7:0] RC_A     = 8'hf0;
  localparam logic [7:0] RC_B     = 8'hb4;
  localparam logic [7:0] RC_STEP  = 8'h0f;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam axh_state_t LANE_IV = '{
    0: 64'h44906568b77b9832,
    1: 64'hcd8d6cae53455532,
    2: 64'hf7b5212756422129,
    3: 64'h246885e1de0d225b,
    4: 64'ha8cb5ce33449973f
  };

endpackage

FILE: design/axh_round.sv
// One Ascon permutation round: constant addition, S-box layer, linear layer.
module axh_round (
  input  axh_pkg::axh_state_t lanes_in,
  input  logic [7:0]          rc,
  output axh_pkg::axh_state_t lanes_out
);
  import axh_pkg::*;

  function automatic axh_lane_t rotr(input axh_lane_t v, input int unsigned n);
    logic [127:0] t;
    t = {v, v} >> n;
    return t[63:0];
  endfunction

  axh_lane_t a, b, c, d, e;
  axh_lane_t t0, t1, t2, t3, t4;
  axh_lane_t sa, sb, sc, sd, se;

  // Add round constant and run the bit-sliced S-box
  always_comb begin
    a = lanes_in[0];
    b = lanes_in[1];
    c = lanes_in[2] ^ {56'd0, rc};
    d = lanes_in[3];
    e = lanes_in[4];
    a = a ^ e;
    e = e ^ d;
    c = c ^ b;
    t0 = ~a & b;
    t1 = ~b & c;
    t2 = ~c & d;
    t3 = ~d & e;
    t4 = ~e & a;
    a = a ^ t1;
    b = b ^ t2;
    c = c ^ t3;
    d = d ^ t4;
    e = e ^ t0;
    b = b ^ a;
    a = a ^ e;
    d = d ^ c;
    c = ~c;
    sa = a;
    sb = b;
    sc = c;
    sd = d;
    se = e;
  end

  // Linear diffusion per lane
  always_comb begin
    lanes_out[0] = sa ^ rotr(sa, 19) ^ rotr(sa, 28);
    lanes_out[1] = sb ^ rotr(sb, 61) ^ rotr(sb, 39);
    lanes_out[2] = sc ^ rotr(sc, 1)  ^ rotr(sc, 6);
    lanes_out[3] = sd ^ rotr(sd, 10) ^ rotr(sd, 17);
    lanes_out[4] = se ^ rotr(se, 7)  ^ rotr(se, 41);
  end

endmodule

FILE: design/ascon_xofa_hash_sponge.sv
// Ascon-XofA hash with a fixed digest of OUT_BLOCKS 64-bit words. One round unit is reused
// once per clock under a small sequencer, so a full 8-byte block runs 8 rounds (the first
// round runs in the accept cycle) and the block is not ready meanwhile. A final block of
// 0 to 7 bytes runs ROUNDS_A rounds, then each digest word is held on the output until
// taken; taking a word that is not the last starts the next 8-round permutation, and
// taking the last word returns the state to the initial value at once. While permuting,
// the single round unit sets the pace at one round per cycle; during the squeeze the
// receiver's stalls add to that, and no new request is taken until the last word is taken.
`include "ascon_xofa_hash_sponge_defines.svh"

module ascon_xofa_hash_sponge #(
  parameter int OUT_BLOCKS = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  axh_pkg::axh_in_t  in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output axh_pkg::axh_out_t out_item
);
  import axh_pkg::*;

  localparam int CW = (OUT_BLOCKS > 1) ? $clog2(OUT_BLOCKS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PERM = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]  state;
  axh_state_t  lanes;
  logic [7:0]  rc;
  logic [3:0]  rnd_left;
  logic        squeeze;
  logic [CW-1:0] blk_cnt;

  axh_state_t  round_in;
  axh_state_t  round_out;
  logic [7:0]  round_rc;
  axh_lane_t   padded;
  axh_lane_t   absorb_word;
  logic        blk_last;

  // Shared round unit
  axh_round u_round (
    .lanes_in  (round_in),
    .rc        (round_rc),
    .lanes_out (round_out)
  );

  // Mask bytes past the count and place the padding byte
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      if (3'(i) < in_item.final_bytes) begin
        padded[63-8*i -: 8] = in_item.block_data[63-8*i -: 8];
      end else if (3'(i) == in_item.final_bytes) begin
        padded[63-8*i -: 8] = PAD_BYTE;
      end else begin
        padded[63-8*i -: 8] = 8'd0;
      end
    end
    absorb_word = in_item.is_final ? padded : in_item.block_data;
  end

  // Select round unit input: absorb on accept, restart on squeeze, else iterate
  always_comb begin
    round_in = lanes;
    round_rc = rc;
    case (state)
      ST_IDLE: begin
        round_in[0] = lanes[0] ^ absorb_word;
        round_rc    = in_item.is_final ? RC_A : RC_B;
      end
      ST_OUT: begin
        round_rc = RC_B;
      end
      default: begin
        round_rc = rc;
      end
    endcase
  end

  assign blk_last  = (blk_cnt == CW'(OUT_BLOCKS - 1));
  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);
  assign out_item.digest_word = lanes[0];
  assign out_item.digest_last = blk_last;

  // Sequencer and sponge state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      lanes    <= LANE_IV;
      rc       <= 8'd0;
      rnd_left <= 4'd0;
      squeeze  <= 1'b0;
      blk_cnt  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            lanes    <= round_out;
            rc       <= round_rc - RC_STEP;
            rnd_left <= in_item.is_final ? ROUNDS_A - 4'd1 : ROUNDS_B - 4'd1;
            squeeze  <= in_item.is_final;
            blk_cnt  <= '0;
            state    <= ST_PERM;
          end
        end
        ST_PERM: begin
          lanes    <= round_out;
          rc       <= rc - RC_STEP;
          rnd_left <= rnd_left - 4'd1;
          if (rnd_left == 4'd1) begin
            state <= squeeze ? ST_OUT : ST_IDLE;
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            if (blk_last) begin
              lanes   <= LANE_IV;
              squeeze <= 1'b0;
              state   <= ST_IDLE;
            end else begin
              lanes    <= round_out;
              rc       <= RC_B - RC_STEP;
              rnd_left <= ROUNDS_B - 4'd1;
              blk_cnt  <= blk_cnt + CW'(1);
              state    <= ST_PERM;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Intake and output never open together
  `AXH_ASSERT_ALWAYS(a_ready_excl, !(in_ready && out_valid))
  // A permutation in progress always has rounds left
  `AXH_ASSERT_ALWAYS(a_rounds_left, (state != ST_PERM) || (rnd_left != 4'd0))
  // Output only appears while squeezing
  `AXH_ASSERT_ALWAYS(a_out_squeeze, !out_valid || squeeze)
  // A full block starts an 8-round permutation
  `AXH_ASSERT_NEXT(a_absorb_len, in_valid && in_ready && !in_item.is_final,
    (state == ST_PERM) && (rnd_left == ROUNDS_B - 4'd1))
  // The last digest word returns the sponge to its initial value
  `AXH_ASSERT_NEXT(a_iv_restore, out_valid && out_ready && out_item.digest_last,
    (state == ST_IDLE) && (lanes == LANE_IV))

endmodule
